// ===== src/gdo_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Grid density objective package
// Register indexes, field widths and sequencer state encoding.
// -----------------------------------------------------------------------------
package gdo_pkg;

   localparam int COORD_W  = 32;
   localparam int GEN_W    = 16;
   localparam int INDEX_W  = 6;
   localparam int SCORE_W  = 32;
   localparam int REQ_DW   = 48;
   localparam int RSP_DW   = 40;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 16;

   localparam logic [CSR_AW-1:0] CSR_NUM_POINTS = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_NUM_DIMS   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_GEN_LIMIT  = 2'd2;

   typedef enum logic [18:0] {
      ST_IDLE     = 19'b000_0000_0000_0000_0001,
      ST_MM_RD    = 19'b000_0000_0000_0000_0010,
      ST_MM_UPD   = 19'b000_0000_0000_0000_0100,
      ST_GR_RD    = 19'b000_0000_0000_0000_1000,
      ST_GR_MUL   = 19'b000_0000_0000_0001_0000,
      ST_GR_DIV   = 19'b000_0000_0000_0010_0000,
      ST_DS_DIAG  = 19'b000_0000_0000_0100_0000,
      ST_DS_RDA   = 19'b000_0000_0000_1000_0000,
      ST_DS_RDB   = 19'b000_0000_0001_0000_0000,
      ST_DS_ACC   = 19'b000_0000_0010_0000_0000,
      ST_DS_WR2   = 19'b000_0000_0100_0000_0000,
      ST_NN_RD    = 19'b000_0000_1000_0000_0000,
      ST_NN_UPD   = 19'b000_0001_0000_0000_0000,
      ST_RAD      = 19'b000_0010_0000_0000_0000,
      ST_SC_START = 19'b000_0100_0000_0000_0000,
      ST_SC_RD    = 19'b000_1000_0000_0000_0000,
      ST_SC_ACC   = 19'b001_0000_0000_0000_0000,
      ST_SC_MUL   = 19'b010_0000_0000_0000_0000,
      ST_SC_OUT   = 19'b100_0000_0000_0000_0000
   } state_type;

endpackage

// ===== src/grid_density_objective.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Grid density objective
// Loads a batch of points, grids them, builds Manhattan distances and emits a
// density score per point. One shared restoring divider under a sequencer.
//
// channel | direction | transaction
// req     | in        | one coordinate (tdata), tlast on the final one
// rsp     | out       | one score per point, tlast on the final point
// csr     | in        | register write, index + data
//
// Loading accepts one coordinate per cycle. On the final coordinate the block
// starts computing, for a time set by the one-bit-per-cycle divider and the
// single-port table reads.
// req_tready is low from the final coordinate until the last score is taken;
// each score waits in the output register while rsp_tready is low.
// Reset is synchronous; it clears control state and loads the register defaults.
// -----------------------------------------------------------------------------
module grid_density_objective #(
   parameter int MAX_POINTS = 64,
   parameter int MAX_DIMS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gdo_pkg::REQ_DW-1:0]    req_tdata,  // coord_value[31:0], generation[47:32]
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gdo_pkg::RSP_DW-1:0]    rsp_tdata,  // point_index[5:0], density_score[37:6]
   output logic                          rsp_tuser,  // zero_radius
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [gdo_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [gdo_pkg::CSR_DW-1:0]    csr_wdata
);
   import gdo_pkg::*;

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int JW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DEPTH  = MAX_POINTS * MAX_DIMS;
   localparam int ADDRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DAW    = $clog2(MAX_POINTS * MAX_POINTS);
   localparam int CELLW  = $clog2(MAX_POINTS + 1);
   localparam int DISTW  = $clog2(MAX_DIMS * (MAX_POINTS - 1) + 1);
   localparam int SUMW   = DISTW + PW + 1;
   localparam int RW     = DISTW + 19;
   localparam int DGW    = DISTW + GEN_W;
   localparam int NUMA   = PW + 32;
   localparam int NUMB   = SUMW + GEN_W + 18;
   localparam int NUMW   = (NUMA > NUMB) ? NUMA : NUMB;
   localparam int DIVW   = (RW > 32) ? RW : 32;
   localparam int DCW    = $clog2(NUMW + 1);
   localparam int SCW    = NUMW + 2;

   // configuration
   logic [6:0]        num_points_ff;
   logic [3:0]        num_dims_ff;
   logic [GEN_W-1:0]  gen_limit_ff;

   // memories
   logic signed [COORD_W-1:0] coord_mem [DEPTH];
   logic [CELLW-1:0]          grid_mem  [DEPTH];
   logic [DISTW-1:0]          dist_mem  [MAX_POINTS*MAX_POINTS];
   logic signed [COORD_W-1:0] cdat_ff;
   logic [CELLW-1:0]          gdat_ff;
   logic [DISTW-1:0]          ddat_ff;

   // sequencer state
   state_type               state_ff, state_in;
   logic [ADDRW-1:0]        load_cnt_ff, load_cnt_in;
   logic [PW:0]             n_ff, n_in;
   logic [JW:0]             d_ff, d_in;
   logic [GEN_W-1:0]        g_ff, g_in;
   logic [GEN_W-1:0]        t_ff, t_in;
   logic [ADDRW-1:0]        addr_ff, addr_in;
   logic [ADDRW-1:0]        base_i_ff, base_i_in;
   logic [ADDRW-1:0]        base_k_ff, base_k_in;
   logic [PW-1:0]           i_ff, i_in;
   logic [PW-1:0]           k_ff, k_in;
   logic [JW-1:0]           j_ff, j_in;
   logic signed [COORD_W-1:0] min_ff [MAX_DIMS];
   logic signed [COORD_W-1:0] min_in [MAX_DIMS];
   logic signed [COORD_W-1:0] max_ff [MAX_DIMS];
   logic signed [COORD_W-1:0] max_in [MAX_DIMS];
   logic [CELLW-1:0]        a_ff, a_in;
   logic [DISTW-1:0]        acc_ff, acc_in;
   logic [DISTW-1:0]        mn_ff, mn_in;
   logic                    first_ff, first_in;
   logic [DISTW-1:0]        dmax_ff, dmax_in;
   logic signed [RW-1:0]    r_ff, r_in;
   logic [SUMW-1:0]         sum_ff, sum_in;
   logic [PW:0]             cnt_ff, cnt_in;

   // shared divider
   logic [NUMW-1:0]         dnum_ff, dnum_in;
   logic [DIVW-1:0]         dden_ff, dden_in;
   logic [DIVW-1:0]         drem_ff, drem_in;
   logic [DCW-1:0]          dcnt_ff, dcnt_in;

   // output register
   logic                    ovalid_ff, ovalid_in;
   logic [INDEX_W-1:0]      oidx_ff, oidx_in;
   logic [SCORE_W-1:0]      oscore_ff, oscore_in;
   logic                    ozero_ff, ozero_in;
   logic                    olast_ff, olast_in;

   // memory ports
   logic                    gwe;
   logic [CELLW-1:0]        gwdata;
   logic [ADDRW-1:0]        graddr;
   logic                    dwe;
   logic [DAW-1:0]          dwaddr;
   logic [DISTW-1:0]        dwdata;
   logic [DAW-1:0]          draddr;

   // datapath
   logic                    req_acc;
   logic [JW-1:0]           d_last;
   logic [PW-1:0]           n_last;
   logic signed [COORD_W:0] off_w, span_w;
   logic [CELLW-1:0]        diff;
   logic [DISTW-1:0]        acc_new;
   logic [DISTW-1:0]        mn_new;
   logic [DIVW:0]           rem_sh;
   logic                    rem_ge;
   logic [DGW-1:0]          dg;
   logic signed [17:0]      gt;
   logic signed [RW-1:0]    r_mul;
   logic [SCW-1:0]          sc_wide;
   logic [SCORE_W-1:0]      sc_sat;

   function automatic logic [DAW-1:0] dist_addr(input logic [PW-1:0] row,
                                                input logic [PW-1:0] col);
      dist_addr = DAW'(row) * DAW'(MAX_POINTS) + DAW'(col);
   endfunction

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign d_last     = JW'(d_ff - 1'b1);
   assign n_last     = PW'(n_ff - 1'b1);

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {2'b00, oscore_ff, oidx_ff};
   assign rsp_tuser  = ozero_ff;
   assign rsp_tlast  = olast_ff;

   assign off_w   = {cdat_ff[COORD_W-1], cdat_ff} - {min_ff[j_ff][COORD_W-1], min_ff[j_ff]};
   assign span_w  = {max_ff[j_ff][COORD_W-1], max_ff[j_ff]}
                  - {min_ff[j_ff][COORD_W-1], min_ff[j_ff]};
   assign diff    = (a_ff > gdat_ff) ? (a_ff - gdat_ff) : (gdat_ff - a_ff);
   assign acc_new = acc_ff + DISTW'(diff);
   assign rem_sh  = {drem_ff, dnum_ff[NUMW-1]};
   assign rem_ge  = (rem_sh >= {1'b0, dden_ff});
   assign dg      = DGW'(ddat_ff) * DGW'(g_ff);
   assign gt      = $signed({2'b00, g_ff}) - $signed({2'b00, t_ff}) + 18'sd1;
   assign r_mul   = $signed({1'b0, dmax_ff}) * gt;
   assign sc_wide = SCW'(dnum_ff) - (SCW'(cnt_ff) << 16);

   always_comb begin
      if ($signed(sc_wide) > $signed({{(SCW-31){1'b0}}, 31'h7FFF_FFFF})) begin
         sc_sat = 32'h7FFF_FFFF;
      end else if ($signed(sc_wide) < $signed({{(SCW-32){1'b1}}, 32'h8000_0000})) begin
         sc_sat = 32'h8000_0000;
      end else begin
         sc_sat = sc_wide[SCORE_W-1:0];
      end
   end

   always_comb begin
      if (first_ff || (ddat_ff < mn_ff)) begin
         mn_new = ddat_ff;
      end else begin
         mn_new = mn_ff;
      end
      if (k_ff == i_ff) begin
         mn_new = mn_ff;
      end
   end

   always_comb begin
      graddr = (state_ff == ST_DS_RDB) ? (base_k_ff + ADDRW'(j_ff))
                                       : (base_i_ff + ADDRW'(j_ff));
      draddr = dist_addr(i_ff, k_ff);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      n_in        = n_ff;
      d_in        = d_ff;
      g_in        = g_ff;
      t_in        = t_ff;
      addr_in     = addr_ff;
      base_i_in   = base_i_ff;
      base_k_in   = base_k_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      a_in        = a_ff;
      acc_in      = acc_ff;
      mn_in       = mn_ff;
      first_in    = first_ff;
      dmax_in     = dmax_ff;
      r_in        = r_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      dnum_in     = dnum_ff;
      dden_in     = dden_ff;
      drem_in     = drem_ff;
      dcnt_in     = dcnt_ff;
      ovalid_in   = ovalid_ff;
      oidx_in     = oidx_ff;
      oscore_in   = oscore_ff;
      ozero_in    = ozero_ff;
      olast_in    = olast_ff;
      gwe         = 1'b0;
      gwdata      = CELLW'(1);
      dwe         = 1'b0;
      dwaddr      = dist_addr(i_ff, i_ff);
      dwdata      = '0;

      // divider also steps in the output state before the score is posted
      if ((state_ff == ST_GR_DIV || state_ff == ST_SC_OUT) && dcnt_ff != '0) begin
         drem_in = rem_ge ? DIVW'(rem_sh - {1'b0, dden_ff}) : DIVW'(rem_sh);
         dnum_in = {dnum_ff[NUMW-2:0], rem_ge};
         dcnt_in = dcnt_ff - 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tlast) begin
                  load_cnt_in = '0;
                  if (num_points_ff < 7'd2) begin
                     n_in = (PW+1)'(2);
                  end else if (32'(num_points_ff) > MAX_POINTS) begin
                     n_in = (PW+1)'(MAX_POINTS);
                  end else begin
                     n_in = (PW+1)'(num_points_ff);
                  end
                  if (num_dims_ff == 4'd0) begin
                     d_in = (JW+1)'(1);
                  end else if (32'(num_dims_ff) > MAX_DIMS) begin
                     d_in = (JW+1)'(MAX_DIMS);
                  end else begin
                     d_in = (JW+1)'(num_dims_ff);
                  end
                  g_in     = (gen_limit_ff == '0) ? GEN_W'(1) : gen_limit_ff;
                  t_in     = req_tdata[COORD_W +: GEN_W];
                  addr_in  = '0;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_MM_RD;
               end else if (32'(load_cnt_ff) == DEPTH - 1) begin
                  load_cnt_in = '0;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_MM_RD: begin
            state_in = ST_MM_UPD;
         end
         ST_MM_UPD: begin
            if (i_ff == '0) begin
               min_in[j_ff] = cdat_ff;
               max_in[j_ff] = cdat_ff;
            end else begin
               if (cdat_ff > max_ff[j_ff]) max_in[j_ff] = cdat_ff;
               if (cdat_ff < min_ff[j_ff]) min_in[j_ff] = cdat_ff;
            end
            addr_in  = addr_ff + 1'b1;
            state_in = ST_MM_RD;
            if (j_ff == d_last) begin
               j_in = '0;
               if (i_ff == n_last) begin
                  addr_in  = '0;
                  i_in     = '0;
                  state_in = ST_GR_RD;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_GR_RD: begin
            state_in = ST_GR_MUL;
         end
         ST_GR_MUL, ST_GR_DIV: begin
            if (state_ff == ST_GR_MUL && span_w != '0) begin
               dnum_in  = NUMW'(n_last) * NUMW'(off_w[COORD_W-1:0]);
               dden_in  = DIVW'(span_w[COORD_W-1:0]);
               drem_in  = '0;
               dcnt_in  = DCW'(NUMW);
               state_in = ST_GR_DIV;
            end else if (state_ff == ST_GR_MUL || dcnt_ff == '0) begin
               gwe      = 1'b1;
               gwdata   = (state_ff == ST_GR_MUL) ? CELLW'(1)
                                                  : CELLW'(dnum_ff[CELLW-1:0] + 1'b1);
               addr_in  = addr_ff + 1'b1;
               state_in = ST_GR_RD;
               if (j_ff == d_last) begin
                  j_in = '0;
                  if (i_ff == n_last) begin
                     i_in      = '0;
                     base_i_in = '0;
                     state_in  = ST_DS_DIAG;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_DS_DIAG: begin
            dwe    = 1'b1;
            dwaddr = dist_addr(i_ff, i_ff);
            dwdata = '0;
            if (i_ff == n_last) begin
               i_in     = '0;
               k_in     = '0;
               dmax_in  = '0;
               first_in = 1'b1;
               state_in = ST_NN_RD;
            end else begin
               k_in      = i_ff + 1'b1;
               base_k_in = base_i_ff + ADDRW'(d_ff);
               j_in      = '0;
               acc_in    = '0;
               state_in  = ST_DS_RDA;
            end
         end
         ST_DS_RDA: begin
            state_in = ST_DS_RDB;
         end
         ST_DS_RDB: begin
            a_in     = gdat_ff;
            state_in = ST_DS_ACC;
         end
         ST_DS_ACC: begin
            acc_in = acc_new;
            if (j_ff == d_last) begin
               dwe      = 1'b1;
               dwaddr   = dist_addr(i_ff, k_ff);
               dwdata   = acc_new;
               state_in = ST_DS_WR2;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_DS_RDA;
            end
         end
         ST_DS_WR2: begin
            dwe    = 1'b1;
            dwaddr = dist_addr(k_ff, i_ff);
            dwdata = acc_ff;
            if (k_ff == n_last) begin
               i_in      = i_ff + 1'b1;
               base_i_in = base_i_ff + ADDRW'(d_ff);
               state_in  = ST_DS_DIAG;
            end else begin
               k_in      = k_ff + 1'b1;
               base_k_in = base_k_ff + ADDRW'(d_ff);
               j_in      = '0;
               acc_in    = '0;
               state_in  = ST_DS_RDA;
            end
         end
         ST_NN_RD: begin
            state_in = ST_NN_UPD;
         end
         ST_NN_UPD: begin
            mn_in    = mn_new;
            state_in = ST_NN_RD;
            if (k_ff != i_ff) first_in = 1'b0;
            if (k_ff == n_last) begin
               if (mn_new > dmax_ff) dmax_in = mn_new;
               first_in = 1'b1;
               k_in     = '0;
               if (i_ff == n_last) begin
                  state_in = ST_RAD;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_RAD: begin
            r_in     = r_mul;
            i_in     = '0;
            state_in = ST_SC_START;
         end
         ST_SC_START: begin
            sum_in = '0;
            cnt_in = '0;
            k_in   = '0;
            if (r_ff > 0) begin
               state_in = ST_SC_RD;
            end else begin
               ovalid_in = 1'b1;
               oidx_in   = INDEX_W'(i_ff);
               oscore_in = '0;
               ozero_in  = (r_ff == '0);
               olast_in  = (i_ff == n_last);
               state_in  = ST_SC_OUT;
            end
         end
         ST_SC_RD: begin
            state_in = ST_SC_ACC;
         end
         ST_SC_ACC: begin
            if (RW'(dg) < $unsigned(r_ff)) begin
               sum_in = sum_ff + SUMW'(ddat_ff);
               cnt_in = cnt_ff + 1'b1;
            end
            if (k_ff == n_last) begin
               state_in = ST_SC_MUL;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_SC_RD;
            end
         end
         ST_SC_MUL: begin
            dnum_in  = (NUMW'(sum_ff) * NUMW'(g_ff) << 17) + NUMW'($unsigned(r_ff));
            dden_in  = DIVW'($unsigned(r_ff)) << 1;
            drem_in  = '0;
            dcnt_in  = DCW'(NUMW);
            state_in = ST_SC_OUT;
            ovalid_in = 1'b0;
            // divider runs while waiting in the output state with valid low
         end
         ST_SC_OUT: begin
            if (!ovalid_ff) begin
               if (dcnt_ff == '0) begin
                  ovalid_in = 1'b1;
                  oidx_in   = INDEX_W'(i_ff);
                  oscore_in = sc_sat;
                  ozero_in  = 1'b0;
                  olast_in  = (i_ff == n_last);
               end
            end else if (rsp_tready) begin
               ovalid_in = 1'b0;
               if (i_ff == n_last) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_SC_START;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_cnt_ff   <= '0;
         ovalid_ff     <= 1'b0;
         dcnt_ff       <= '0;
         num_points_ff <= 7'd64;
         num_dims_ff   <= 4'd2;
         gen_limit_ff  <= 16'd100;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         ovalid_ff   <= ovalid_in;
         dcnt_ff     <= dcnt_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_NUM_POINTS: num_points_ff <= csr_wdata[6:0];
               CSR_NUM_DIMS:   num_dims_ff   <= csr_wdata[3:0];
               CSR_GEN_LIMIT:  gen_limit_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      d_ff      <= d_in;
      g_ff      <= g_in;
      t_ff      <= t_in;
      addr_ff   <= addr_in;
      base_i_ff <= base_i_in;
      base_k_ff <= base_k_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      a_ff      <= a_in;
      acc_ff    <= acc_in;
      mn_ff     <= mn_in;
      first_ff  <= first_in;
      dmax_ff   <= dmax_in;
      r_ff      <= r_in;
      sum_ff    <= sum_in;
      cnt_ff    <= cnt_in;
      dnum_ff   <= dnum_in;
      dden_ff   <= dden_in;
      drem_ff   <= drem_in;
      oidx_ff   <= oidx_in;
      oscore_ff <= oscore_in;
      ozero_ff  <= ozero_in;
      olast_ff  <= olast_in;
   end

   // storage
   always_ff @(posedge clock) begin
      if (req_acc) begin
         coord_mem[load_cnt_ff] <= req_tdata[COORD_W-1:0];
      end
      cdat_ff <= coord_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (gwe) begin
         grid_mem[addr_ff] <= gwdata;
      end
      gdat_ff <= grid_mem[graddr];
   end

   always_ff @(posedge clock) begin
      if (dwe) begin
         dist_mem[dwaddr] <= dwdata;
      end
      ddat_ff <= dist_mem[draddr];
   end

   // checks
   a_no_accept_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while a result is pending");

   a_cell_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GR_DIV && dcnt_ff == '0) |-> (dnum_ff < NUMW'(n_ff)))
      else $error("grid cell beyond point count");

   a_zero_radius_score: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[37:6] == '0))
      else $error("zero radius with non-zero score");

   a_load_restart: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (load_cnt_ff == '0))
      else $error("load counter not cleared after final coordinate");

endmodule

// ===== tb/grid_density_objective_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Grid density objective testbench
// Streams batches of Q16.16 points into the block under randomised burst and
// stall timing, predicts every per-point density score from its own copy of
// the coordinate store and register set, and checks each result transaction
// field by field in arrival order.
// -----------------------------------------------------------------------------
module grid_density_objective_tb;
   import gdo_pkg::*;

   localparam int  STORE_DEPTH = 512;
   localparam int  CYCLE_LIMIT = 2000000;
   localparam int  LONG_STALL  = 3000;
   localparam int  BUF_DEPTH   = 1024;

   typedef struct {
      logic [31:0] coord;
      logic [15:0] gen;
      logic        last;
   } coord_item_type;

   typedef struct {
      logic [5:0]  idx;
      logic [31:0] score;
      logic        zero_rad;
      logic        last;
   } score_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata = '0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_addr = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;

   grid_density_objective u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // pending coordinates and expected scores, ring buffers
   coord_item_type pend_buf[BUF_DEPTH];
   int             pend_wr = 0;
   int             pend_rd = 0;
   score_item_type exp_buf[BUF_DEPTH];
   int             exp_wr = 0;
   int             exp_rd = 0;
   coord_item_type drive_item;
   int             mismatches = 0;
   int             cycles = 0;
   int             stim_items = 0;

   // predictor state
   logic [6:0]   cfg_points = 7'd64;
   logic [3:0]   cfg_dims = 4'd2;
   logic [15:0]  cfg_gen_limit = 16'd100;
   longint       coord_mem[STORE_DEPTH];
   int           cell_mem[STORE_DEPTH];
   int           dist_tab[64][64];
   int           load_ptr = 0;

   // stimulus side mirror of which store entries hold data
   bit           stim_written[STORE_DEPTH];

   // sender / receiver timing
   int           burst_left = 0;
   int           gap_left = 0;
   logic [15:0]  stall_pattern = 16'hFFFF;
   int           pattern_pos = 0;
   int           stall_cnt = 0;
   bit           stall_request = 0;
   bit           stall_taken = 0;

   function automatic int eff_points();
      return (cfg_points < 2) ? 2 : (cfg_points > 64) ? 64 : int'(cfg_points);
   endfunction

   function automatic int eff_dims();
      return (cfg_dims < 1) ? 1 : (cfg_dims > 8) ? 8 : int'(cfg_dims);
   endfunction

   function automatic longint eff_gen_limit();
      return (cfg_gen_limit == 0) ? 64'sd1 : longint'(cfg_gen_limit);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compute_scores(input longint t);
      int n, d, i, j, k, mn, s, a, b;
      longint g, r, dmax, span, off, sum, cnt, q, score;
      longint mins[8];
      longint maxs[8];
      score_item_type e;
      n = eff_points();
      d = eff_dims();
      g = eff_gen_limit();
      for (j = 0; j < d; j++) begin
         mins[j] = coord_mem[j];
         maxs[j] = coord_mem[j];
         for (i = 1; i < n; i++) begin
            if (coord_mem[i*d+j] > maxs[j]) maxs[j] = coord_mem[i*d+j];
            if (coord_mem[i*d+j] < mins[j]) mins[j] = coord_mem[i*d+j];
         end
      end
      for (i = 0; i < n; i++)
         for (j = 0; j < d; j++) begin
            span = maxs[j] - mins[j];
            off = coord_mem[i*d+j] - mins[j];
            cell_mem[i*d+j] = (span > 0) ? int'(((n - 1) * off) / span) + 1 : 1;
         end
      for (i = 0; i < n; i++) begin
         dist_tab[i][i] = 0;
         for (k = i + 1; k < n; k++) begin
            s = 0;
            for (j = 0; j < d; j++) begin
               a = cell_mem[i*d+j];
               b = cell_mem[k*d+j];
               s += (a > b) ? a - b : b - a;
            end
            dist_tab[i][k] = s;
            dist_tab[k][i] = s;
         end
      end
      dmax = 0;
      for (i = 0; i < n; i++) begin
         mn = dist_tab[i][(i == 0) ? 1 : 0];
         for (k = 0; k < n; k++)
            if (k != i && dist_tab[i][k] < mn) mn = dist_tab[i][k];
         if (longint'(mn) > dmax) dmax = mn;
      end
      r = dmax * (g - t + 1);
      for (i = 0; i < n; i++) begin
         score = 0;
         if (r > 0) begin
            sum = 0;
            cnt = 0;
            for (k = 0; k < n; k++)
               if (longint'(dist_tab[i][k]) * g < r) begin
                  sum += dist_tab[i][k];
                  cnt++;
               end
            q = (sum * g * 131072 + r) / (2 * r);
            score = q - cnt * 65536;
            if (score > 64'sd2147483647) score = 64'sd2147483647;
            if (score < -64'sd2147483648) score = -64'sd2147483648;
         end
         e.idx = i[5:0];
         e.score = score[31:0];
         e.zero_rad = (r == 0);
         e.last = (i == n - 1);
         exp_buf[exp_wr % BUF_DEPTH] = e;
         exp_wr++;
      end
   endtask

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pend_wr != pend_rd) begin
            drive_item = pend_buf[pend_rd % BUF_DEPTH];
            pend_rd++;
            req_tdata <= {drive_item.gen, drive_item.coord};
            req_tlast <= drive_item.last;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // input monitor feeding the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         coord_mem[load_ptr] = longint'($signed(req_tdata[31:0]));
         load_ptr = (load_ptr + 1) % STORE_DEPTH;
         if (req_tlast) begin
            load_ptr = 0;
            compute_scores(longint'(req_tdata[47:32]));
         end
      end
   end

   // receiver: own stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
         rsp_tready <= 1'b0;
         stall_cnt <= stall_cnt - 1;
      end else if (stall_request && !stall_taken && rsp_tvalid) begin
         rsp_tready <= 1'b0;
         stall_cnt <= LONG_STALL;
         stall_taken <= 1;
      end else begin
         rsp_tready <= stall_pattern[pattern_pos];
         if (pattern_pos == 15) begin
            pattern_pos <= 0;
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
         end else begin
            pattern_pos <= pattern_pos + 1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      score_item_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_wr == exp_rd) begin
            report_mismatch($sformatf("unexpected result idx %0d", rsp_tdata[5:0]));
         end else begin
            e = exp_buf[exp_rd % BUF_DEPTH];
            exp_rd++;
            if (rsp_tdata[5:0] !== e.idx)
               report_mismatch($sformatf("point_index %0d exp %0d", rsp_tdata[5:0], e.idx));
            if (rsp_tdata[37:6] !== e.score)
               report_mismatch($sformatf("idx %0d density_score %h exp %h",
                                         e.idx, rsp_tdata[37:6], e.score));
            if (rsp_tuser !== e.zero_rad)
               report_mismatch($sformatf("idx %0d zero_radius %b exp %b",
                                         e.idx, rsp_tuser, e.zero_rad));
            if (rsp_tlast !== e.last)
               report_mismatch($sformatf("idx %0d last_result %b exp %b",
                                         e.idx, rsp_tlast, e.last));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_NUM_POINTS: cfg_points = val[6:0];
         CSR_NUM_DIMS:   cfg_dims = val[3:0];
         CSR_GEN_LIMIT:  cfg_gen_limit = val;
         default: ;
      endcase
   endtask

   task automatic wait_drain();
      while (pend_wr != pend_rd || req_tvalid || exp_wr != exp_rd)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_generation();
      logic [15:0] g;
      g = 16'(eff_gen_limit());
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'd1;
         2: return g;
         3: return g + 16'd1;
         4: return g + 16'd2;
         5: return 16'hFFFF;
         6: return 16'($urandom_range(0, g));
         default: return 16'($urandom);
      endcase
   endfunction

   // mode: 0 random, 1 clustered, 2 extremes, 3 all equal, 4 first dim flat
   task automatic add_batch(input int len_req, input int mode, input logic [15:0] t);
      int len, need, i;
      bit ok;
      coord_item_type it;
      logic [31:0] base;
      need = eff_points() * eff_dims();
      len = len_req;
      if (len < 1) len = 1;
      ok = 1;
      for (i = len; i < need; i++)
         if (!stim_written[i]) ok = 0;
      if (!ok) len = need;
      base = $urandom;
      for (i = 0; i < len; i++) begin
         case (mode)
            0: it.coord = $urandom;
            1: it.coord = base + 32'($urandom_range(0, 3) << 16);
            2: case ($urandom_range(0, 3))
                  0: it.coord = 32'h8000_0000;
                  1: it.coord = 32'h7FFF_FFFF;
                  2: it.coord = 32'h0000_0000;
                  default: it.coord = 32'hFFFF_FFFF;
               endcase
            3: it.coord = base;
            default: it.coord = (i % eff_dims() == 0) ? base : $urandom;
         endcase
         it.gen = (i == len - 1) ? t : 16'($urandom);
         it.last = (i == len - 1);
         stim_written[i] = 1;
         pend_buf[pend_wr % BUF_DEPTH] = it;
         pend_wr++;
         stim_items++;
      end
   endtask

   initial begin
      int b, nb, need, len, sel;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      add_batch(128, 0, pick_generation());
      wait_drain();

      // directed: N=3, D=2, G=1
      csr_write(CSR_NUM_POINTS, 16'd3);
      csr_write(CSR_NUM_DIMS, 16'd2);
      csr_write(CSR_GEN_LIMIT, 16'd1);
      add_batch(6, 2, 16'd0);
      add_batch(6, 3, 16'd1);
      add_batch(6, 0, 16'd2);
      add_batch(6, 4, 16'd6);
      add_batch(2, 1, 16'd1);
      add_batch(8, 0, 16'hFFFF);
      wait_drain();

      // clamped extremes with a long receiver hold-off
      csr_write(CSR_NUM_POINTS, 16'd127);
      csr_write(CSR_NUM_DIMS, 16'd0);
      csr_write(CSR_GEN_LIMIT, 16'd0);
      stall_request = 1;
      add_batch(64, 0, 16'd0);
      add_batch(64, 1, 16'd1);
      wait_drain();

      csr_write(CSR_NUM_POINTS, 16'd1);
      csr_write(CSR_NUM_DIMS, 16'd15);
      csr_write(CSR_GEN_LIMIT, 16'hFFFF);
      csr_write(2'd3, 16'($urandom));
      add_batch(16, 2, 16'hFFFF);
      add_batch(16, 0, 16'd0);
      wait_drain();

      while (stim_items < 400) begin
         csr_write(CSR_NUM_POINTS,
                   {9'($urandom), ($urandom_range(0, 7) == 0) ? 7'($urandom_range(9, 20))
                                                              : 7'($urandom_range(2, 8))});
         csr_write(CSR_NUM_DIMS, {12'($urandom), 4'($urandom_range(1, 4))});
         sel = $urandom_range(0, 3);
         csr_write(CSR_GEN_LIMIT, (sel == 0) ? 16'd1 : (sel == 1) ? 16'($urandom_range(2, 20))
                                                     : 16'($urandom));
         nb = $urandom_range(2, 4);
         for (b = 0; b < nb; b++) begin
            need = eff_points() * eff_dims();
            sel = $urandom_range(0, 9);
            len = (sel == 0) ? $urandom_range(1, need) :
                  (sel == 1) ? need + $urandom_range(1, 3) : need;
            sel = $urandom_range(0, 9);
            add_batch(len, (sel < 5) ? 0 : (sel < 7) ? 1 : sel - 5, pick_generation());
         end
         wait_drain();
      end
      wait_drain();
      repeat (200) @(posedge clock);

      if (exp_wr != exp_rd)
         report_mismatch($sformatf("%0d results never arrived", exp_wr - exp_rd));
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
